// ----- hdl/rai_pkg.sv -----
// Shared types and constants for the ray versus box slab test pipeline.
package rai_pkg;

    localparam int NUM_AXES  = 3;
    localparam int COORD_W   = 32;
    localparam int DIR_W     = 18;
    localparam int THR_W     = 17;
    localparam int DIST_W    = 31;
    localparam int NORM_W    = 2;
    localparam int STEP_BITS = 4;
    localparam int PROD_W    = DIR_W + COORD_W;
    localparam int OFF_W     = COORD_W + 2;
    localparam int S_DATA_W  = 344;
    localparam int M_DATA_W  = 136;

    localparam logic [THR_W-1:0]  THR_RESET = THR_W'(1);
    localparam logic [NORM_W-1:0] NORM_POS  = 2'b01;
    localparam logic [NORM_W-1:0] NORM_NEG  = 2'b11;
    localparam logic [NORM_W-1:0] NORM_NONE = 2'b00;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIR_W-1:0]   dir_t;
    typedef coord_t [NUM_AXES-1:0]     coord3_t;
    typedef dir_t [NUM_AXES-1:0]       dir3_t;

    typedef struct packed {
        coord3_t              org;
        dir3_t                dir;
        coord3_t              lo;
        coord3_t              hi;
        logic [NUM_AXES-1:0]  par;
        logic                 par_rej;
    } side_t;

endpackage

// ----- hdl/rai_div.sv -----
// Pipelined unsigned restoring divider with signed, saturated 32-bit quotient.
module rai_div import rai_pkg::*; #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 18
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [NUM_W-1:0]      num_mag,
    input  logic [DEN_W-1:0]      den_mag,
    input  logic                  neg,
    output coord_t                quot
);

    localparam int STAGES = (NUM_W + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W  = STAGES * STEP_BITS;

    logic [PAD_W-1:0] work_reg [STAGES+1];
    logic [DEN_W-1:0] rem_reg  [STAGES+1];
    logic [DEN_W-1:0] den_reg  [STAGES+1];
    logic             neg_reg  [STAGES+1];
    coord_t           quot_reg;

    assign work_reg[0] = PAD_W'(num_mag);
    assign rem_reg[0]  = '0;
    assign den_reg[0]  = den_mag;
    assign neg_reg[0]  = neg;

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [PAD_W-1:0] work_next;
        logic [DEN_W-1:0] rem_next;

        always_comb begin
            logic [DEN_W:0]   r;
            logic [PAD_W-1:0] w;
            r = {1'b0, rem_reg[s]};
            w = work_reg[s];
            for (int j = 0; j < STEP_BITS; j++) begin
                r = {r[DEN_W-1:0], w[PAD_W-1]};
                w = {w[PAD_W-2:0], 1'b0};
                if (r >= {1'b0, den_reg[s]}) begin
                    r = r - {1'b0, den_reg[s]};
                    w[0] = 1'b1;
                end
            end
            work_next = w;
            rem_next  = r[DEN_W-1:0];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                work_reg[s+1] <= work_next;
                rem_reg[s+1]  <= rem_next;
                den_reg[s+1]  <= den_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
            end
        end
    end

    logic [NUM_W-1:0] q;
    logic             q_big;
    logic             q_half;
    coord_t           quot_next;

    always_comb begin
        q      = work_reg[STAGES][NUM_W-1:0];
        q_big  = |q[NUM_W-1:COORD_W-1];
        q_half = q[COORD_W-1] && (q[NUM_W-1:COORD_W] == '0) && (q[COORD_W-2:0] == '0);
        if (!neg_reg[STAGES]) begin
            quot_next = q_big ? COORD_MAX : coord_t'(q[COORD_W-1:0]);
        end else begin
            quot_next = (q_big && !q_half) ? COORD_MIN : coord_t'(-q[COORD_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

// ----- hdl/rai_post.sv -----
// Interval folding, hit point and face normal stages after the slab divisions.
module rai_post import rai_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  side_t                     side,
    input  coord3_t                   t_lo,
    input  coord3_t                   t_hi,
    output logic                      out_valid,
    output logic                      hit,
    output logic [DIST_W-1:0]         distance,
    output coord3_t                   point,
    output logic [NUM_AXES-1:0][NORM_W-1:0] normal
);

    logic    f1_vld_reg, f2_vld_reg, m_vld_reg, p_vld_reg, o_vld_reg;
    side_t   f1_side_reg, f2_side_reg, m_side_reg, p_side_reg;
    coord3_t f1_lo_reg, f1_hi_reg, f1_lo_next, f1_hi_next;
    coord_t  f2_tmin_reg, f2_tmin_next, m_tmin_reg, p_tmin_reg;
    logic    f2_hit_reg, f2_hit_next, m_hit_reg, p_hit_reg;
    logic signed [NUM_AXES-1:0][PROD_W-1:0] m_prod_reg, m_prod_next;
    coord3_t p_pt_reg, p_pt_next;
    logic    o_hit_reg;
    logic [DIST_W-1:0] o_dist_reg;
    coord3_t o_pt_reg;
    logic [NUM_AXES-1:0][NORM_W-1:0] o_norm_reg, o_norm_next;

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            if (side.par[i]) begin
                f1_lo_next[i] = '0;
                f1_hi_next[i] = COORD_MAX;
            end else if ($signed(t_lo[i]) > $signed(t_hi[i])) begin
                f1_lo_next[i] = t_hi[i];
                f1_hi_next[i] = t_lo[i];
            end else begin
                f1_lo_next[i] = t_lo[i];
                f1_hi_next[i] = t_hi[i];
            end
        end
    end

    always_comb begin
        coord_t tmax;
        f2_tmin_next = '0;
        tmax = COORD_MAX;
        for (int i = 0; i < NUM_AXES; i++) begin
            if ($signed(f1_lo_reg[i]) > $signed(f2_tmin_next)) f2_tmin_next = f1_lo_reg[i];
            if ($signed(f1_hi_reg[i]) < $signed(tmax)) tmax = f1_hi_reg[i];
        end
        f2_hit_next = !f1_side_reg.par_rej && ($signed(f2_tmin_next) <= $signed(tmax));
    end

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            m_prod_next[i] = PROD_W'($signed(f2_side_reg.dir[i]) * $signed(f2_tmin_reg));
        end
    end

    always_comb begin
        logic signed [PROD_W-1:0] adj;
        logic signed [PROD_W:0]   sum;
        for (int i = 0; i < NUM_AXES; i++) begin
            adj = m_prod_reg[i][PROD_W-1]
                ? $signed(m_prod_reg[i]) + $signed(PROD_W'((1 << FRAC_BITS) - 1))
                : $signed(m_prod_reg[i]);
            sum = $signed({adj[PROD_W-1], adj}) >>> FRAC_BITS;
            sum = sum + $signed((PROD_W+1)'($signed(m_side_reg.org[i])));
            if (sum > $signed((PROD_W+1)'(COORD_MAX))) begin
                p_pt_next[i] = COORD_MAX;
            end else if (sum < $signed((PROD_W+1)'(COORD_MIN))) begin
                p_pt_next[i] = COORD_MIN;
            end else begin
                p_pt_next[i] = sum[COORD_W-1:0];
            end
        end
    end

    always_comb begin
        logic signed [NUM_AXES-1:0][OFF_W-1:0] off;
        logic [NUM_AXES-1:0][OFF_W-1:0] mag;
        for (int i = 0; i < NUM_AXES; i++) begin
            off[i] = $signed({p_pt_reg[i][COORD_W-1], p_pt_reg[i], 1'b0})
                   - ($signed(OFF_W'($signed(p_side_reg.lo[i])))
                   + $signed(OFF_W'($signed(p_side_reg.hi[i]))));
            mag[i] = off[i][OFF_W-1] ? OFF_W'(-off[i]) : off[i];
            o_norm_next[i] = NORM_NONE;
        end
        if (mag[0] > mag[1] && mag[0] > mag[2]) begin
            o_norm_next[0] = ($signed(off[0]) > 0) ? NORM_POS : NORM_NEG;
        end else if (mag[1] > mag[2]) begin
            o_norm_next[1] = ($signed(off[1]) > 0) ? NORM_POS : NORM_NEG;
        end else begin
            o_norm_next[2] = ($signed(off[2]) > 0) ? NORM_POS : NORM_NEG;
        end
        if (!p_hit_reg) begin
            o_norm_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
            p_vld_reg  <= 1'b0;
            o_vld_reg  <= 1'b0;
        end else if (en) begin
            f1_vld_reg <= in_valid;
            f2_vld_reg <= f1_vld_reg;
            m_vld_reg  <= f2_vld_reg;
            p_vld_reg  <= m_vld_reg;
            o_vld_reg  <= p_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_side_reg <= side;
            f1_lo_reg   <= f1_lo_next;
            f1_hi_reg   <= f1_hi_next;
            f2_side_reg <= f1_side_reg;
            f2_tmin_reg <= f2_tmin_next;
            f2_hit_reg  <= f2_hit_next;
            m_side_reg  <= f2_side_reg;
            m_tmin_reg  <= f2_tmin_reg;
            m_hit_reg   <= f2_hit_reg;
            m_prod_reg  <= m_prod_next;
            p_side_reg  <= m_side_reg;
            p_tmin_reg  <= m_tmin_reg;
            p_hit_reg   <= m_hit_reg;
            p_pt_reg    <= p_pt_next;
            o_hit_reg   <= p_hit_reg;
            o_dist_reg  <= p_hit_reg ? p_tmin_reg[DIST_W-1:0] : '0;
            o_pt_reg    <= p_hit_reg ? p_pt_reg : '0;
            o_norm_reg  <= o_norm_next;
        end
    end

    assign out_valid = o_vld_reg;
    assign hit       = o_hit_reg;
    assign distance  = o_dist_reg;
    assign point     = o_pt_reg;
    assign normal    = o_norm_reg;

endmodule

// ----- hdl/ray_aabb_intersect_unit.sv -----
// Ray versus axis-aligned box slab intersection, fully pipelined.
// Throughput: one transaction per cycle; an output stall holds the whole pipeline.
// Order: input prep register, slab dividers, then folding, hit point, normal.
// The depth is set by the six pipelined slab dividers, four quotient bits per stage.
// Reset (synchronous, aresetn low) clears all valid bits and sets the threshold to 1.
module ray_aabb_intersect_unit import rai_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [THR_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, zero pad
    input  logic [S_DATA_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // distance, point_x, point_y, point_z, normal_x, normal_y, normal_z, zero pad
    output logic [M_DATA_W-1:0]   m_tdata,
    // hit
    output logic [0:0]            m_tuser
);

    localparam int NUM_W   = COORD_W + 1 + FRAC_BITS;
    localparam int DIV_LAT = (NUM_W + STEP_BITS - 1) / STEP_BITS + 1;

    logic              en;
    logic [THR_W-1:0]  thr_reg;

    side_t side_in;
    logic [NUM_AXES-1:0][NUM_W-1:0] nlo_next, nhi_next, nlo_reg, nhi_reg;
    logic [NUM_AXES-1:0][DIR_W-1:0] den_next, den_reg;
    logic [NUM_AXES-1:0]            neglo_next, neghi_next, neglo_reg, neghi_reg;
    side_t prep_side_reg;
    logic  prep_vld_reg;

    side_t dly_side_reg [DIV_LAT];
    logic  dly_vld_reg  [DIV_LAT];

    coord3_t t_lo, t_hi;

    logic    post_valid, post_hit;
    logic [DIST_W-1:0] post_dist;
    coord3_t post_pt;
    logic [NUM_AXES-1:0][NORM_W-1:0] post_norm;

    assign en       = !post_valid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    always_comb begin
        logic signed [COORD_W:0] dlo, dhi;
        logic [DIR_W-1:0]        mag;
        side_in.par_rej = 1'b0;
        for (int i = 0; i < NUM_AXES; i++) begin
            side_in.org[i] = s_tdata[COORD_W*i +: COORD_W];
            side_in.dir[i] = s_tdata[COORD_W*NUM_AXES + DIR_W*i +: DIR_W];
            side_in.lo[i]  = s_tdata[(COORD_W+DIR_W)*NUM_AXES + COORD_W*i +: COORD_W];
            side_in.hi[i]  = s_tdata[(2*COORD_W+DIR_W)*NUM_AXES + COORD_W*i +: COORD_W];
            mag = side_in.dir[i][DIR_W-1] ? DIR_W'(-side_in.dir[i]) : side_in.dir[i];
            side_in.par[i] = (side_in.dir[i] == '0) || (mag < {1'b0, thr_reg});
            if (side_in.par[i] && (($signed(side_in.org[i]) < $signed(side_in.lo[i])) ||
                                   ($signed(side_in.org[i]) > $signed(side_in.hi[i])))) begin
                side_in.par_rej = 1'b1;
            end
            dlo = $signed({side_in.lo[i][COORD_W-1], side_in.lo[i]})
                - $signed({side_in.org[i][COORD_W-1], side_in.org[i]});
            dhi = $signed({side_in.hi[i][COORD_W-1], side_in.hi[i]})
                - $signed({side_in.org[i][COORD_W-1], side_in.org[i]});
            nlo_next[i] = {(dlo[COORD_W] ? (COORD_W+1)'(-dlo) : dlo), {FRAC_BITS{1'b0}}};
            nhi_next[i] = {(dhi[COORD_W] ? (COORD_W+1)'(-dhi) : dhi), {FRAC_BITS{1'b0}}};
            neglo_next[i] = dlo[COORD_W] ^ side_in.dir[i][DIR_W-1];
            neghi_next[i] = dhi[COORD_W] ^ side_in.dir[i][DIR_W-1];
            den_next[i]   = mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_vld_reg <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++) dly_vld_reg[k] <= 1'b0;
        end else if (en) begin
            prep_vld_reg   <= s_tvalid;
            dly_vld_reg[0] <= prep_vld_reg;
            for (int k = 1; k < DIV_LAT; k++) dly_vld_reg[k] <= dly_vld_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prep_side_reg   <= side_in;
            nlo_reg         <= nlo_next;
            nhi_reg         <= nhi_next;
            den_reg         <= den_next;
            neglo_reg       <= neglo_next;
            neghi_reg       <= neghi_next;
            dly_side_reg[0] <= prep_side_reg;
            for (int k = 1; k < DIV_LAT; k++) dly_side_reg[k] <= dly_side_reg[k-1];
        end
    end

    for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
        rai_div #(.NUM_W(NUM_W), .DEN_W(DIR_W)) u_div_lo (
            .aclk    (aclk),
            .en      (en),
            .num_mag (nlo_reg[i]),
            .den_mag (den_reg[i]),
            .neg     (neglo_reg[i]),
            .quot    (t_lo[i])
        );
        rai_div #(.NUM_W(NUM_W), .DEN_W(DIR_W)) u_div_hi (
            .aclk    (aclk),
            .en      (en),
            .num_mag (nhi_reg[i]),
            .den_mag (den_reg[i]),
            .neg     (neghi_reg[i]),
            .quot    (t_hi[i])
        );
    end

    rai_post #(.FRAC_BITS(FRAC_BITS)) u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dly_vld_reg[DIV_LAT-1]),
        .side      (dly_side_reg[DIV_LAT-1]),
        .t_lo      (t_lo),
        .t_hi      (t_hi),
        .out_valid (post_valid),
        .hit       (post_hit),
        .distance  (post_dist),
        .point     (post_pt),
        .normal    (post_norm)
    );

    assign m_tvalid   = post_valid;
    assign m_tuser[0] = post_hit;
    assign m_tdata    = M_DATA_W'({post_norm[2], post_norm[1], post_norm[0],
                                   post_pt[2], post_pt[1], post_pt[0], post_dist});

endmodule

// ----- hdl/rai_checker.sv -----
// Port-level assertions for the ray versus box unit, bound to the top level.
module rai_checker import rai_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [0:0]          m_tuser
);

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled result transaction changed.");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("Result valid after reset.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("Miss transaction carries nonzero data.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
        $countones({m_tdata[128:127] != 2'b00, m_tdata[130:129] != 2'b00,
                    m_tdata[132:131] != 2'b00}) == 1 &&
        m_tdata[127+:2] != 2'b10 && m_tdata[129+:2] != 2'b10 && m_tdata[131+:2] != 2'b10)
        else $error("Hit transaction without exactly one face normal.");

    assert property (@(posedge aclk)
        s_tvalid && !s_tready |-> m_tvalid && !m_tready)
        else $error("Input transaction held back without an output stall.");

endmodule

bind ray_aabb_intersect_unit rai_checker u_rai_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
